>>> design/tvs_pkg.sv
`timescale 1ns / 1ps
// Package for the timed valve sequencer: codes, widths, reset values and the
// shared types and a helper function. No dependencies.
package tvs_pkg;

    // Default sizes handed to the top level parameters.
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int NUM_EVENTS_DEF   = 4;
    localparam int NUM_TANKS_DEF    = 4;
    localparam int START_WINDOW_DEF = 10;

    // Field widths.
    localparam int TIME_W      = 17;
    localparam int MASK_W      = 8;
    localparam int LEVEL_W     = 7;
    localparam int MODE_W      = 2;
    localparam int DURATION_W  = 12;
    localparam int EVENT_W     = 25;
    localparam int PAIR_W      = 50;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 50;
    localparam int CURSOR_W    = 3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EVENT_COUNT     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WATER_DURATION  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TANK_USAGE      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TANK_MAP        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_EVENT_PAIR_LOW  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_EVENT_PAIR_HIGH = 3'd6;

    // Register reset values.
    localparam logic [3:0]            CHANNEL_COUNT_RST  = 4'd1;
    localparam logic [2:0]            EVENT_COUNT_RST    = 3'd0;
    localparam logic [DURATION_W-1:0] WATER_DURATION_RST = 12'd60;
    localparam logic [LEVEL_W-1:0]    TANK_USAGE_RST     = 7'd5;

    localparam logic [TIME_W-1:0]  RESET_WINDOW = 17'd60;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL   = 7'd100;

    typedef enum logic [MODE_W-1:0] {
        MODE_WAITING  = 2'd0,
        MODE_WATERING = 2'd1,
        MODE_DONE     = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        EV_WAITING = 2'd0,
        EV_ONGOING = 2'd1,
        EV_DONE    = 2'd2
    } t_ev_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_STEP,
        S_EMIT
    } t_ctl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic start;
        logic step;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go_step;
        logic step_done;
        logic out_free;
    } t_sts;

    // Unpacks one 25-bit event (start time in the low 17 bits, mask above).
    function automatic logic [EVENT_W-1:0] ev_field(
        input logic [PAIR_W-1:0] pair_low,
        input logic [PAIR_W-1:0] pair_high,
        input logic [1:0]        idx
    );
        logic [PAIR_W-1:0] pair;
        pair = idx[1] ? pair_high : pair_low;
        return idx[0] ? pair[PAIR_W-1:EVENT_W] : pair[EVENT_W-1:0];
    endfunction

endpackage

>>> design/tvs_in_if.sv
`timescale 1ns / 1ps
// Input channel of the timed valve sequencer: one time-of-day word per tick.
// Depends on tvs_pkg for the field width.
interface tvs_in_if;
    logic                      valid;
    logic                      ready;
    logic [tvs_pkg::TIME_W-1:0] time_of_day;

    modport source (output valid, output time_of_day, input ready);
    modport sink   (input valid, input time_of_day, output ready);
endinterface

>>> design/tvs_out_if.sv
`timescale 1ns / 1ps
// Output channel of the timed valve sequencer: valve mask, tank levels, mode.
// Depends on tvs_pkg for the field widths.
interface tvs_out_if;
    logic                        valid;
    logic                        ready;
    logic [tvs_pkg::MASK_W-1:0]  valve_mask;
    logic [tvs_pkg::LEVEL_W-1:0] level_tank_zero;
    logic [tvs_pkg::LEVEL_W-1:0] level_tank_one;
    logic [tvs_pkg::LEVEL_W-1:0] level_tank_two;
    logic [tvs_pkg::LEVEL_W-1:0] level_tank_three;
    logic [tvs_pkg::MODE_W-1:0]  mode;

    modport source (output valid, output valve_mask, output level_tank_zero,
                    output level_tank_one, output level_tank_two,
                    output level_tank_three, output mode, input ready);
    modport sink   (input valid, input valve_mask, input level_tank_zero,
                    input level_tank_one, input level_tank_two,
                    input level_tank_three, input mode, output ready);
endinterface

>>> design/tvs_ctrl.sv
`timescale 1ns / 1ps
// Controller of the timed valve sequencer: sequences capture, start decision,
// channel steps and result load. Depends on tvs_pkg.
module tvs_ctrl #(
    parameter int NUM_CHANNELS = tvs_pkg::NUM_CHANNELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tvs_pkg::t_sts i_sts,
    output tvs_pkg::t_cmd o_cmd
);
    // A running event visits every channel at most once plus the wrap.
    localparam int STEP_LIMIT = NUM_CHANNELS + 2;
    localparam int SCW        = $clog2(STEP_LIMIT);

    tvs_pkg::t_ctl_state r_state, n_state;
    logic [SCW-1:0]      r_step_cnt, n_step_cnt;
    logic                last_step;

    assign last_step = (r_step_cnt == SCW'(STEP_LIMIT - 1));

    always_comb begin
        n_state    = r_state;
        n_step_cnt = r_step_cnt;
        unique case (r_state)
            tvs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = tvs_pkg::S_START;
                end
            end
            tvs_pkg::S_START: begin
                n_step_cnt = '0;
                n_state    = i_sts.go_step ? tvs_pkg::S_STEP : tvs_pkg::S_EMIT;
            end
            tvs_pkg::S_STEP: begin
                n_step_cnt = r_step_cnt + SCW'(1);
                if (i_sts.step_done || last_step) begin
                    n_state = tvs_pkg::S_EMIT;
                end
            end
            tvs_pkg::S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = tvs_pkg::S_IDLE;
                end
            end
            default: n_state = tvs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd          = '0;
        unique case (r_state)
            tvs_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            tvs_pkg::S_START: o_cmd.start = 1'b1;
            tvs_pkg::S_STEP:  o_cmd.step  = 1'b1;
            tvs_pkg::S_EMIT:  o_cmd.load_out = i_sts.out_free;
            default: o_in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= tvs_pkg::S_IDLE;
            r_step_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_step_cnt <= n_step_cnt;
        end
    end

endmodule

>>> design/tvs_datapath.sv
`timescale 1ns / 1ps
// Datapath of the timed valve sequencer: configuration registers, event and
// channel state, tank levels and the result register. Depends on tvs_pkg.
module tvs_datapath #(
    parameter int NUM_CHANNELS = tvs_pkg::NUM_CHANNELS_DEF,
    parameter int NUM_EVENTS   = tvs_pkg::NUM_EVENTS_DEF,
    parameter int NUM_TANKS    = tvs_pkg::NUM_TANKS_DEF,
    parameter int START_WINDOW = tvs_pkg::START_WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tvs_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [tvs_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [tvs_pkg::TIME_W-1:0]          i_time_of_day,
    input  tvs_pkg::t_cmd                       i_cmd,
    output tvs_pkg::t_sts                       o_sts,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [tvs_pkg::MASK_W-1:0]          o_valve_mask,
    output logic [tvs_pkg::LEVEL_W-1:0]         o_level_tank_zero,
    output logic [tvs_pkg::LEVEL_W-1:0]         o_level_tank_one,
    output logic [tvs_pkg::LEVEL_W-1:0]         o_level_tank_two,
    output logic [tvs_pkg::LEVEL_W-1:0]         o_level_tank_three,
    output logic [tvs_pkg::MODE_W-1:0]          o_mode
);
    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int EW = (NUM_EVENTS > 1) ? $clog2(NUM_EVENTS) : 1;
    localparam int TW = (NUM_TANKS > 1) ? $clog2(NUM_TANKS) : 1;
    localparam int TIME_W  = tvs_pkg::TIME_W;
    localparam int LEVEL_W = tvs_pkg::LEVEL_W;

    // Configuration registers.
    logic [3:0]                       r_channel_count;
    logic [2:0]                       r_event_count;
    logic [tvs_pkg::DURATION_W-1:0]   r_water_duration;
    logic [LEVEL_W-1:0]               r_tank_usage;
    logic [15:0]                      r_tank_map;
    logic [tvs_pkg::PAIR_W-1:0]       r_event_pair_low;
    logic [tvs_pkg::PAIR_W-1:0]       r_event_pair_high;

    // Sequencer state.
    tvs_pkg::t_mode                   r_mode, n_mode;
    tvs_pkg::t_ev_status              r_ev_status [NUM_EVENTS];
    tvs_pkg::t_ev_status              n_ev_status [NUM_EVENTS];
    logic [tvs_pkg::CURSOR_W-1:0]     r_cursor, n_cursor;
    logic [TIME_W-1:0]                r_open_since, n_open_since;
    logic [NUM_CHANNELS-1:0]          r_channel_open, n_channel_open;
    logic [LEVEL_W-1:0]               r_tank_level [NUM_TANKS];
    logic [LEVEL_W-1:0]               n_tank_level [NUM_TANKS];
    logic [TIME_W-1:0]                r_time;

    // Result register.
    logic                             r_out_valid;
    logic [tvs_pkg::MASK_W-1:0]       r_out_valve_mask;
    logic [LEVEL_W-1:0]               r_out_level [4];
    logic [tvs_pkg::MODE_W-1:0]       r_out_mode;

    logic [2:0]                       nev;
    logic [3:0]                       nch;
    logic                             start_hit, run_found;
    logic [EW-1:0]                    start_idx, run_idx;
    logic [tvs_pkg::MASK_W-1:0]       run_mask;
    logic                             ch_in_range, ch_en, ch_open, expired;
    logic [CW-1:0]                    ch_idx;
    logic [1:0]                       tank_sel;
    logic                             tank_ok, drain_ok;
    logic [TW-1:0]                    tank_idx;
    logic                             last_ch, last_ev, rearm;
    logic [tvs_pkg::EVENT_W-1:0]      run_ev;
    logic [tvs_pkg::MASK_W-1:0]       vm_pad;
    logic [LEVEL_W-1:0]               lv_pad [4];

    assign nev = (r_event_count > 3'(NUM_EVENTS)) ? 3'(NUM_EVENTS) : r_event_count;
    assign nch = (r_channel_count == 4'd0) ? 4'd1 :
                 (r_channel_count > 4'(NUM_CHANNELS)) ? 4'(NUM_CHANNELS) : r_channel_count;

    // First event in use whose start window holds the current time.
    always_comb begin
        logic [tvs_pkg::EVENT_W-1:0] ev;
        logic [TIME_W:0]             win_end;
        start_hit = 1'b0;
        start_idx = '0;
        for (int i = NUM_EVENTS - 1; i >= 0; i--) begin
            ev      = tvs_pkg::ev_field(r_event_pair_low, r_event_pair_high, 2'(i));
            win_end = {1'b0, ev[TIME_W-1:0]} + (TIME_W+1)'(START_WINDOW);
            if ((3'(i) < nev) && (r_time >= ev[TIME_W-1:0])
                && ({1'b0, r_time} <= win_end)) begin
                start_hit = 1'b1;
                start_idx = EW'(i);
            end
        end
    end

    // First running event in use.
    always_comb begin
        run_found = 1'b0;
        run_idx   = '0;
        for (int i = NUM_EVENTS - 1; i >= 0; i--) begin
            if ((3'(i) < nev) && (r_ev_status[i] == tvs_pkg::EV_ONGOING)) begin
                run_found = 1'b1;
                run_idx   = EW'(i);
            end
        end
    end

    assign run_ev   = tvs_pkg::ev_field(r_event_pair_low, r_event_pair_high, 2'(run_idx));
    assign run_mask = run_ev[tvs_pkg::EVENT_W-1:TIME_W];

    assign ch_in_range = ({1'b0, r_cursor} < 4'(NUM_CHANNELS));
    assign ch_idx      = r_cursor[CW-1:0];
    assign ch_en       = ch_in_range && run_mask[r_cursor];
    assign ch_open     = ch_in_range && r_channel_open[ch_idx];
    assign expired     = ({1'b0, r_open_since} + (TIME_W+1)'(r_water_duration))
                         <= {1'b0, r_time};

    assign tank_sel = r_tank_map[{r_cursor, 1'b0} +: 2];
    assign tank_ok  = ({1'b0, tank_sel} < 3'(NUM_TANKS));
    assign tank_idx = tank_sel[TW-1:0];
    assign drain_ok = tank_ok && (r_tank_level[tank_idx] >= r_tank_usage);

    assign last_ch = (({1'b0, r_cursor} + 4'd1) >= nch);
    assign last_ev = ((3'(run_idx) + 3'd1) == nev);
    assign rearm   = (r_time < tvs_pkg::RESET_WINDOW) && (r_mode == tvs_pkg::MODE_DONE);

    assign o_sts.go_step   = !rearm && ((r_mode != tvs_pkg::MODE_WAITING) || start_hit);
    // A step ends the tick when no event runs, a channel opens or keeps running, or the event ends.
    assign o_sts.step_done = !run_found || (ch_en && !(ch_open && expired)) || last_ch;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_mode         = r_mode;
        n_ev_status    = r_ev_status;
        n_cursor       = r_cursor;
        n_open_since   = r_open_since;
        n_channel_open = r_channel_open;
        n_tank_level   = r_tank_level;
        if (i_cmd.start) begin
            if (rearm) begin
                for (int i = 0; i < NUM_EVENTS; i++) begin
                    n_ev_status[i] = tvs_pkg::EV_WAITING;
                end
                n_mode = tvs_pkg::MODE_WAITING;
            end else if ((r_mode == tvs_pkg::MODE_WAITING) && start_hit) begin
                n_ev_status[start_idx] = tvs_pkg::EV_ONGOING;
                n_mode                 = tvs_pkg::MODE_WATERING;
                n_open_since           = r_time;
                n_cursor               = '0;
            end
        end
        if (i_cmd.step && run_found) begin
            if (ch_en && !ch_open) begin
                n_open_since           = r_time;
                n_channel_open[ch_idx] = 1'b1;
            end else if (!ch_en || expired) begin
                if (ch_en) begin
                    n_channel_open[ch_idx] = 1'b0;
                    if (drain_ok) begin
                        n_tank_level[tank_idx] = r_tank_level[tank_idx] - r_tank_usage;
                    end
                end
                n_cursor = r_cursor + 3'd1;
                if (last_ch) begin
                    n_ev_status[run_idx] = tvs_pkg::EV_DONE;
                    n_cursor             = '0;
                    n_mode = last_ev ? tvs_pkg::MODE_DONE : tvs_pkg::MODE_WAITING;
                end
            end
        end
    end

    // Missing channels and tanks read as zero on the output.
    always_comb begin
        vm_pad                   = '0;
        vm_pad[NUM_CHANNELS-1:0] = r_channel_open;
        for (int i = 0; i < 4; i++) begin
            lv_pad[i] = '0;
        end
        for (int i = 0; i < NUM_TANKS; i++) begin
            lv_pad[i] = r_tank_level[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count   <= tvs_pkg::CHANNEL_COUNT_RST;
            r_event_count     <= tvs_pkg::EVENT_COUNT_RST;
            r_water_duration  <= tvs_pkg::WATER_DURATION_RST;
            r_tank_usage      <= tvs_pkg::TANK_USAGE_RST;
            r_tank_map        <= '0;
            r_event_pair_low  <= '0;
            r_event_pair_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tvs_pkg::REG_CHANNEL_COUNT:   r_channel_count   <= i_cfg_data[3:0];
                tvs_pkg::REG_EVENT_COUNT:     r_event_count     <= i_cfg_data[2:0];
                tvs_pkg::REG_WATER_DURATION:
                    r_water_duration <= i_cfg_data[tvs_pkg::DURATION_W-1:0];
                tvs_pkg::REG_TANK_USAGE:      r_tank_usage      <= i_cfg_data[LEVEL_W-1:0];
                tvs_pkg::REG_TANK_MAP:        r_tank_map        <= i_cfg_data[15:0];
                tvs_pkg::REG_EVENT_PAIR_LOW:
                    r_event_pair_low <= i_cfg_data[tvs_pkg::PAIR_W-1:0];
                tvs_pkg::REG_EVENT_PAIR_HIGH:
                    r_event_pair_high <= i_cfg_data[tvs_pkg::PAIR_W-1:0];
                default: r_tank_map <= r_tank_map;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= tvs_pkg::MODE_WAITING;
            r_cursor       <= '0;
            r_open_since   <= '0;
            r_channel_open <= '0;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < NUM_EVENTS; i++) begin
                r_ev_status[i] <= tvs_pkg::EV_WAITING;
            end
            for (int i = 0; i < NUM_TANKS; i++) begin
                r_tank_level[i] <= tvs_pkg::FULL_LEVEL;
            end
        end else begin
            r_mode         <= n_mode;
            r_cursor       <= n_cursor;
            r_open_since   <= n_open_since;
            r_channel_open <= n_channel_open;
            r_ev_status    <= n_ev_status;
            r_tank_level   <= n_tank_level;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_time <= i_time_of_day;
        end
        if (i_cmd.load_out) begin
            r_out_valve_mask <= vm_pad;
            r_out_level      <= lv_pad;
            r_out_mode       <= r_mode;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_valve_mask       = r_out_valve_mask;
    assign o_level_tank_zero  = r_out_level[0];
    assign o_level_tank_one   = r_out_level[1];
    assign o_level_tank_two   = r_out_level[2];
    assign o_level_tank_three = r_out_level[3];
    assign o_mode             = r_out_mode;

endmodule

>>> design/timed_valve_sequencer.sv
`timescale 1ns / 1ps
// Timed valve sequencer: one result word per time-of-day tick.
// Channels: i_in carries the time of day in seconds, o_out carries the valve
// mask, the four tank levels and the mode. Both use valid/ready; a word moves
// on a clock edge where both are high. Registers are written through
// i_cfg_we/i_cfg_index/i_cfg_data; the user must write them only while the
// block is idle, since the block itself does not enforce it.
// A word is captured, the start is decided, the channel loop steps the
// running event one channel per cycle through a single compare and tank
// update, and the result is loaded. One word is in work at a time, so the
// next word is taken once the result is in the output register.
// Reset (synchronous, active low) restores the register defaults, puts every
// event and the sequencer in waiting, closes all valves and fills every tank
// to 100. A stalled receiver holds the result in the output register; the
// block still takes and works the next word and waits with its result until
// the register is free.
module timed_valve_sequencer #(
    parameter int NUM_CHANNELS = tvs_pkg::NUM_CHANNELS_DEF,
    parameter int NUM_EVENTS   = tvs_pkg::NUM_EVENTS_DEF,
    parameter int NUM_TANKS    = tvs_pkg::NUM_TANKS_DEF,
    parameter int START_WINDOW = tvs_pkg::START_WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tvs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tvs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    tvs_in_if.sink                          i_in,
    tvs_out_if.source                       o_out
);
    tvs_pkg::t_cmd cmd;
    tvs_pkg::t_sts sts;

    tvs_ctrl #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tvs_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .NUM_EVENTS   (NUM_EVENTS),
        .NUM_TANKS    (NUM_TANKS),
        .START_WINDOW (START_WINDOW)
    ) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_time_of_day      (i_in.time_of_day),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_valve_mask       (o_out.valve_mask),
        .o_level_tank_zero  (o_out.level_tank_zero),
        .o_level_tank_one   (o_out.level_tank_one),
        .o_level_tank_two   (o_out.level_tank_two),
        .o_level_tank_three (o_out.level_tank_three),
        .o_mode             (o_out.mode)
    );

endmodule

>>> tb/sv/timed_valve_sequencer_test.sv
`timescale 1ns / 1ps
// Self-checking bench for timed_valve_sequencer: drives time-of-day ticks,
// predicts each result word and compares it. Depends on tvs_pkg and the
// tvs_in_if / tvs_out_if interfaces.
module timed_valve_sequencer_test;

    localparam int LIMIT_CYCLES = 1_200_000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 160;
    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_PRINTS   = 100;

    typedef struct packed {
        logic [tvs_pkg::MASK_W-1:0]  valve_mask;
        logic [tvs_pkg::LEVEL_W-1:0] level0;
        logic [tvs_pkg::LEVEL_W-1:0] level1;
        logic [tvs_pkg::LEVEL_W-1:0] level2;
        logic [tvs_pkg::LEVEL_W-1:0] level3;
        logic [tvs_pkg::MODE_W-1:0]  mode;
    } t_valve_word;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_we    = 1'b0;
    logic [tvs_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [tvs_pkg::CFG_DATA_W-1:0]  i_cfg_data  = '0;

    tvs_in_if  in_if ();
    tvs_out_if out_if ();

    timed_valve_sequencer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_if.sink),
        .o_out       (out_if.source)
    );

    // Shadow copy of the registers.
    logic [3:0]                     cfg_channels = tvs_pkg::CHANNEL_COUNT_RST;
    logic [2:0]                     cfg_events   = tvs_pkg::EVENT_COUNT_RST;
    logic [tvs_pkg::DURATION_W-1:0] cfg_duration = tvs_pkg::WATER_DURATION_RST;
    logic [tvs_pkg::LEVEL_W-1:0]    cfg_usage    = tvs_pkg::TANK_USAGE_RST;
    logic [15:0]                    cfg_tank_map = '0;
    logic [tvs_pkg::PAIR_W-1:0]     cfg_pair_lo  = '0;
    logic [tvs_pkg::PAIR_W-1:0]     cfg_pair_hi  = '0;

    // Predicted sequencer state.
    tvs_pkg::t_mode               seq_mode = tvs_pkg::MODE_WAITING;
    tvs_pkg::t_ev_status          ev_state [4];
    logic [tvs_pkg::CURSOR_W-1:0] cursor     = '0;
    logic [tvs_pkg::TIME_W-1:0]   open_since = '0;
    logic [tvs_pkg::MASK_W-1:0]   open_mask  = '0;
    logic [tvs_pkg::LEVEL_W-1:0]  tank_lvl [4];

    logic [tvs_pkg::TIME_W-1:0] pending_ticks [$];
    t_valve_word                expected_words [$];

    int err_count   = 0;
    int cycle_count = 0;
    int tx_gap      = 0;
    int rx_stall    = 0;
    bit idle_on     = 1'b1;

    initial begin
        for (int i = 0; i < 4; i++) begin
            ev_state[i] = tvs_pkg::EV_WAITING;
            tank_lvl[i] = tvs_pkg::FULL_LEVEL;
        end
        in_if.valid       = 1'b0;
        in_if.time_of_day = '0;
        out_if.ready      = 1'b0;
    end

    initial forever #6 i_clk = ~i_clk;

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        if (err_count <= MAX_PRINTS)
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endtask

    function automatic int draw_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [tvs_pkg::EVENT_W-1:0] sched_entry(int e);
        logic [tvs_pkg::PAIR_W-1:0] pair;
        pair = (e < 2) ? cfg_pair_lo : cfg_pair_hi;
        return (e % 2) ? pair[tvs_pkg::PAIR_W-1:tvs_pkg::EVENT_W]
                       : pair[tvs_pkg::EVENT_W-1:0];
    endfunction

    // Works through the channels of the running event for one tick.
    function automatic void step_channels(logic [tvs_pkg::TIME_W-1:0] t);
        int nev, nch, e, c;
        logic [tvs_pkg::EVENT_W-1:0] ent;
        logic [1:0] tk;
        nev = (cfg_events > 4) ? 4 : int'(cfg_events);
        nch = (cfg_channels == 0) ? 1 : ((cfg_channels > 8) ? 8 : int'(cfg_channels));
        e = 0;
        while (e < nev && ev_state[e] != tvs_pkg::EV_ONGOING) e++;
        if (e >= nev) return;
        ent = sched_entry(e);
        for (int guard = 0; guard <= 9; guard++) begin
            c = int'(cursor);
            if (ent[tvs_pkg::TIME_W + c]) begin
                if (!open_mask[c]) begin
                    open_since   = t;
                    open_mask[c] = 1'b1;
                    return;
                end
                if (int'(open_since) + int'(cfg_duration) > int'(t)) return;
                open_mask[c] = 1'b0;
                tk = cfg_tank_map[2*c +: 2];
                if (tank_lvl[tk] >= cfg_usage) tank_lvl[tk] = tank_lvl[tk] - cfg_usage;
            end
            cursor = cursor + 1'b1;
            if (c + 1 >= nch) begin
                ev_state[e] = tvs_pkg::EV_DONE;
                cursor      = '0;
                seq_mode    = (e + 1 == nev) ? tvs_pkg::MODE_DONE : tvs_pkg::MODE_WAITING;
                return;
            end
        end
    endfunction

    function automatic void advance_schedule(logic [tvs_pkg::TIME_W-1:0] t);
        int nev, s;
        t_valve_word w;
        nev = (cfg_events > 4) ? 4 : int'(cfg_events);
        if (t < tvs_pkg::RESET_WINDOW && seq_mode == tvs_pkg::MODE_DONE) begin
            for (int i = 0; i < 4; i++) ev_state[i] = tvs_pkg::EV_WAITING;
            seq_mode = tvs_pkg::MODE_WAITING;
        end else if (seq_mode == tvs_pkg::MODE_WAITING) begin
            for (int i = 0; i < nev; i++) begin
                s = int'(sched_entry(i)
                         & {{tvs_pkg::MASK_W{1'b0}}, {tvs_pkg::TIME_W{1'b1}}});
                if (int'(t) >= s && int'(t) <= s + tvs_pkg::START_WINDOW_DEF) begin
                    ev_state[i] = tvs_pkg::EV_ONGOING;
                    seq_mode    = tvs_pkg::MODE_WATERING;
                    open_since  = t;
                    cursor      = '0;
                    step_channels(t);
                    break;
                end
            end
        end else begin
            step_channels(t);
        end
        w.valve_mask = open_mask;
        w.level0     = tank_lvl[0];
        w.level1     = tank_lvl[1];
        w.level2     = tank_lvl[2];
        w.level3     = tank_lvl[3];
        w.mode       = seq_mode;
        expected_words.insert(expected_words.size(), w);
    endfunction

    // Tick driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) advance_schedule(in_if.time_of_day);
            if (!(in_if.valid && !in_if.ready)) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    in_if.valid <= 1'b0;
                end else if (pending_ticks.size() > 0) begin
                    in_if.valid       <= 1'b1;
                    in_if.time_of_day <= pending_ticks.pop_front();
                    tx_gap = draw_gap();
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin : monitor
        t_valve_word got, want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = {out_if.valve_mask, out_if.level_tank_zero, out_if.level_tank_one,
                       out_if.level_tank_two, out_if.level_tank_three, out_if.mode};
                if (expected_words.size() == 0) begin
                    report_mismatch("unexpected result word", int'(got.valve_mask), -1);
                end else begin
                    want = expected_words.pop_front();
                    if (got.valve_mask !== want.valve_mask)
                        report_mismatch("valve_mask", got.valve_mask, want.valve_mask);
                    if (got.level0 !== want.level0)
                        report_mismatch("level_tank_zero", got.level0, want.level0);
                    if (got.level1 !== want.level1)
                        report_mismatch("level_tank_one", got.level1, want.level1);
                    if (got.level2 !== want.level2)
                        report_mismatch("level_tank_two", got.level2, want.level2);
                    if (got.level3 !== want.level3)
                        report_mismatch("level_tank_three", got.level3, want.level3);
                    if (got.mode !== want.mode)
                        report_mismatch("mode", got.mode, want.mode);
                end
            end
            if (rx_stall > 0) begin
                rx_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                rx_stall = ($urandom_range(0, 3) == 0) ? draw_gap() : 0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(logic [tvs_pkg::CFG_INDEX_W-1:0] idx,
                             logic [tvs_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            tvs_pkg::REG_CHANNEL_COUNT:   cfg_channels = data[3:0];
            tvs_pkg::REG_EVENT_COUNT:     cfg_events   = data[2:0];
            tvs_pkg::REG_WATER_DURATION:  cfg_duration = data[tvs_pkg::DURATION_W-1:0];
            tvs_pkg::REG_TANK_USAGE:      cfg_usage    = data[tvs_pkg::LEVEL_W-1:0];
            tvs_pkg::REG_TANK_MAP:        cfg_tank_map = data[15:0];
            tvs_pkg::REG_EVENT_PAIR_LOW:  cfg_pair_lo  = data[tvs_pkg::PAIR_W-1:0];
            tvs_pkg::REG_EVENT_PAIR_HIGH: cfg_pair_hi  = data[tvs_pkg::PAIR_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(int ch, int ev, int dur, int usage, int map,
                             logic [tvs_pkg::PAIR_W-1:0] lo,
                             logic [tvs_pkg::PAIR_W-1:0] hi);
        write_reg(tvs_pkg::REG_CHANNEL_COUNT, ch);
        write_reg(tvs_pkg::REG_EVENT_COUNT, ev);
        write_reg(tvs_pkg::REG_WATER_DURATION, dur);
        write_reg(tvs_pkg::REG_TANK_USAGE, usage);
        write_reg(tvs_pkg::REG_TANK_MAP, map);
        write_reg(tvs_pkg::REG_EVENT_PAIR_LOW, lo);
        write_reg(tvs_pkg::REG_EVENT_PAIR_HIGH, hi);
    endtask

    // Sampled on the falling edge so that all driver updates have settled.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_ticks.size() > 0 || in_if.valid || expected_words.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_list(int vals[$]);
        foreach (vals[i])
            pending_ticks.insert(pending_ticks.size(), vals[i][tvs_pkg::TIME_W-1:0]);
    endtask

    // Two events starting shortly after base, with random channel masks.
    function automatic logic [tvs_pkg::PAIR_W-1:0] sched_pair(int base);
        logic [tvs_pkg::TIME_W-1:0] s0, s1;
        logic [tvs_pkg::MASK_W-1:0] m0, m1;
        s0 = tvs_pkg::TIME_W'(base + $urandom_range(0, 40));
        s1 = tvs_pkg::TIME_W'(base + $urandom_range(0, 40));
        m0 = ($urandom_range(0, 9) == 0) ? '0 : tvs_pkg::MASK_W'($urandom_range(0, 255));
        m1 = ($urandom_range(0, 9) == 0) ? '0 : tvs_pkg::MASK_W'($urandom_range(0, 255));
        return {m1, s1, m0, s0};
    endfunction

    // Mostly a clock walking forward through the schedule, with jumps back,
    // restarts, ticks inside the reset window and the odd random time.
    task automatic queue_ticks(int n, int base);
        int t, r;
        t = base - $urandom_range(0, 5);
        if (t < 0) t = 0;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                pending_ticks.insert(pending_ticks.size(),
                                     tvs_pkg::TIME_W'($urandom_range(0, 59)));
            end else if (r < 5) begin
                pending_ticks.insert(pending_ticks.size(), tvs_pkg::TIME_W'($urandom));
            end else begin
                if (r < 8) t = base - $urandom_range(0, 3);
                else if (r < 11) t = t - $urandom_range(1, 8);
                else if (r < 13) t = t + $urandom_range(100, 4000);
                else if (r < 25) t = t + $urandom_range(2, 15);
                else t = t + 1;
                if (t < 0) t = 0;
                pending_ticks.insert(pending_ticks.size(), t[tvs_pkg::TIME_W-1:0]);
            end
        end
    endtask

    initial begin
        int ch, ev, dur, usage, map, base;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Register defaults: no event in use, ticks change nothing.
        send_list('{0, 131071, 86399});
        wait_idle();

        // Two events, the second near the top of the time range; covers a
        // restart of a finished event, time going backward, the floor on
        // tank levels and the reset window after all events are done.
        write_all(3, 2, 2, 37, 16'h0021,
                  {8'h82, 17'd131065, 8'h05, 17'd100},
                  {8'hFF, 17'h1FFFF, 8'hFF, 17'h1FFFF});
        send_list('{100, 101, 102, 103, 104, 105, 106, 50, 109, 110, 112,
                    131065, 131066, 131068, 131070, 131071, 200, 59, 30});
        wait_idle();

        // Out-of-range counts and a zero duration.
        write_all(0, 7, 0, 0, 16'hFFFF, {tvs_pkg::PAIR_W{1'b1}}, {tvs_pkg::PAIR_W{1'b1}});
        send_list('{131071, 131071, 131071, 131071, 10, 131070});
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            idle_on = (ph % 4 != 1);
            base = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 30)
                                               : $urandom_range(60, 131000);
            ch    = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            ev    = ($urandom_range(0, 6) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
            dur   = $urandom_range(0, 6);
            if ($urandom_range(0, 4) == 0) dur = $urandom_range(7, 40);
            if ($urandom_range(0, 9) == 0) dur = $urandom_range(0, 4095);
            usage = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 6);
            map   = $urandom_range(0, 65535);
            case (ph)
                0: begin ch = 8;  ev = 4; dur = 1;    usage = 1; end
                2: begin ch = 15; ev = 7; dur = 0;    usage = 0;   map = 0; end
                4: begin ch = 1;  ev = 1; dur = 4095; usage = 127; end
                6: begin ch = 0;  ev = 0; end
                PHASES - 1: begin ch = 8; ev = 4; dur = 3600; usage = 100; map = 16'hFFFF; end
                default: ;
            endcase
            write_all(ch, ev, dur, usage, map, sched_pair(base), sched_pair(base));
            // Halfway through, hold the ticks back until every word is in.
            queue_ticks(PHASE_ITEMS / 2, base);
            wait_idle();
            queue_ticks(PHASE_ITEMS - PHASE_ITEMS / 2, base);
            wait_idle();
        end

        repeat (30) @(posedge i_clk);
        if (expected_words.size() > 0)
            report_mismatch("result words never delivered", 0, expected_words.size());
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
